[sv/tlg_pkg.sv]
package tlg_pkg;

   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 64;
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROWS_USED_W = 6;
   localparam int COLS_USED_W = 7;
   localparam int CSR_DATA_W = 7;
   localparam int NBR_W = 4;

   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_W-1:0] KEEP_LOW = 4'd2;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_STEP = 2'd2;

   localparam logic CSR_ROWS_USED = 1'b0;
   localparam logic CSR_COLS_USED = 1'b1;

   localparam logic [ROWS_USED_W-1:0] ROWS_USED_RESET = 6'd20;
   localparam logic [COLS_USED_W-1:0] COLS_USED_RESET = 7'd40;

   typedef logic [MAX_COLS-1:0] row_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             alive_in;
   } req_type;

   typedef struct packed {
      logic       cell_alive;
      logic [1:0] done_kind;
   } rsp_type;

   typedef struct packed {
      logic             shift;
      logic             wr_en;
      logic [COL_W-1:0] wr_col;
      logic             wr_bit;
   } cell_ctl_type;

endpackage

[sv/toroidal_life_generation_unit.sv]
// Write and read: result registered the cycle after the request; one request per cycle
// while the response side keeps up.
// Step: the row ring rotates once through the rows in use, one row per cycle, and the
// response follows the last of the rows_used rows (3..32); no request is taken meanwhile.
// Synchronous active-high reset clears the grid and sets rows_used 20, cols_used 40.
module toroidal_life_generation_unit
   import tlg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [ROW_W-1:0] cnt_ff, cnt_in;
   logic [ROWS_USED_W-1:0] rows_used_ff, rows_used_in;
   logic [COLS_USED_W-1:0] cols_used_ff, cols_used_in;
   row_type first_ff, first_in;
   row_type prev_ff, prev_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [ROWS_USED_W-1:0] rows_n;
   logic [COLS_USED_W-1:0] cols_n;
   logic [ROW_W-1:0] last_row;
   logic accept;
   logic sweep;
   logic sweep_last;
   row_type cell_row [MAX_ROWS];
   row_type above, below, new_row;
   row_type sel_row;

   // clamp sizes into the legal range
   always_comb begin
      if (rows_used_ff < ROWS_USED_W'(3)) begin
         rows_n = ROWS_USED_W'(3);
      end else if (rows_used_ff > ROWS_USED_W'(MAX_ROWS)) begin
         rows_n = ROWS_USED_W'(MAX_ROWS);
      end else begin
         rows_n = rows_used_ff;
      end
      if (cols_used_ff < COLS_USED_W'(3)) begin
         cols_n = COLS_USED_W'(3);
      end else if (cols_used_ff > COLS_USED_W'(MAX_COLS)) begin
         cols_n = COLS_USED_W'(MAX_COLS);
      end else begin
         cols_n = cols_used_ff;
      end
   end

   assign last_row = ROW_W'(rows_n - ROWS_USED_W'(1));
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign sweep = (state_ff == ST_SWEEP);
   assign sweep_last = sweep && (cnt_ff >= last_row);

   // old neighbors of the row at the head of the ring
   assign above = (cnt_ff == '0) ? cell_row[last_row] : prev_ff;
   assign below = sweep_last ? first_ff : cell_row[1];
   assign sel_row = cell_row[req_data.row];

   tlg_row_rule u_rule (
      .above    (above),
      .cur      (cell_row[0]),
      .below    (below),
      .cols_n   (cols_n),
      .next_row (new_row)
   );

   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
      cell_ctl_type ctl;
      row_type      shift_row;

      assign ctl.shift = sweep && (ROW_W'(i) <= last_row);
      assign ctl.wr_en = accept && (req_data.command == CMD_WRITE)
                       && (req_data.row == ROW_W'(i));
      assign ctl.wr_col = req_data.col;
      assign ctl.wr_bit = req_data.alive_in;

      if (i < MAX_ROWS - 1) begin : g_mid
         assign shift_row = (ROW_W'(i) == last_row) ? new_row : cell_row[i+1];
      end else begin : g_end
         assign shift_row = new_row;
      end

      tlg_row_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .shift_row (shift_row),
         .row_out   (cell_row[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      first_in = first_ff;
      prev_in = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_USED: rows_used_in = csr_wdata[ROWS_USED_W-1:0];
            CSR_COLS_USED: cols_used_in = csr_wdata[COLS_USED_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.done_kind = req_data.command;
               rsp_in.cell_alive = 1'b0;
               if (req_data.command == CMD_STEP) begin
                  state_in = ST_SWEEP;
                  cnt_in = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (req_data.command == CMD_READ) begin
                     rsp_in.cell_alive = sel_row[req_data.col];
                  end
               end
            end
         end
         ST_SWEEP: begin
            prev_in = cell_row[0];
            if (cnt_ff == '0) begin
               first_in = cell_row[0];
            end
            cnt_in = cnt_ff + ROW_W'(1);
            if (sweep_last) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rows_used_ff <= ROWS_USED_RESET;
         cols_used_ff <= COLS_USED_RESET;
         rsp_valid_ff <= 1'b0;
         first_ff <= '0;
         prev_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff <= first_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.command == CMD_STEP) |=> (state_ff == ST_SWEEP) && (cnt_ff == '0))
      else $error("step request did not start a sweep at row zero");

   a_no_rsp_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !rsp_valid_ff)
      else $error("response pending during sweep");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.command != CMD_STEP)
      |=> rsp_valid_ff && (rsp_ff.done_kind == $past(req_data.command)))
      else $error("write or read response missing or wrong kind");

endmodule

[sv/tlg_row_cell.sv]
module tlg_row_cell
   import tlg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  row_type      shift_row,
   output row_type      row_out
);

   row_type row_ff;
   row_type row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.shift) begin
         row_in = shift_row;
      end else if (ctl.wr_en) begin
         row_in[ctl.wr_col] = ctl.wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

[sv/tlg_row_rule.sv]
module tlg_row_rule
   import tlg_pkg::*;
(
   input  row_type                above,
   input  row_type                cur,
   input  row_type                below,
   input  logic [COLS_USED_W-1:0] cols_n,
   output row_type                next_row
);

   logic [COL_W-1:0] last_col;
   logic [COL_W-1:0] lf;
   logic [COL_W-1:0] rt;
   logic [NBR_W-1:0] n;

   assign last_col = COL_W'(cols_n - COLS_USED_W'(1));

   always_comb begin
      next_row = cur;
      for (int c = 0; c < MAX_COLS; c++) begin
         lf = (c == 0) ? last_col : COL_W'(c - 1);
         rt = (COL_W'(c) == last_col) ? '0 : COL_W'(c + 1);
         n = NBR_W'(above[lf]) + NBR_W'(above[c]) + NBR_W'(above[rt])
           + NBR_W'(cur[lf]) + NBR_W'(cur[rt])
           + NBR_W'(below[lf]) + NBR_W'(below[c]) + NBR_W'(below[rt]);
         if (COLS_USED_W'(c) < cols_n) begin
            if (cur[c]) begin
               next_row[c] = (n == KEEP_LOW) || (n == BIRTH_COUNT);
            end else begin
               next_row[c] = (n == BIRTH_COUNT);
            end
         end
      end
   end

endmodule
